### design/tfn_pkg.sv
package tfn_pkg;

  // Field widths of the stream items
  localparam int COORD_W = 16;
  localparam int INDEX_W = 16;
  localparam int OUT_W   = 16;
  localparam int CNT_W   = 16;

  // Datapath widths
  localparam int DIFF_W    = COORD_W + 1;        // edge vector component
  localparam int CROSS_W   = 2 * DIFF_W + 1;     // signed cross product component
  localparam int MAG_W     = CROSS_W - 1;        // its magnitude
  localparam int SCL_W     = 20;                 // magnitude after block scaling
  localparam int MUL_W     = SCL_W + 1;          // signed multiplier operand
  localparam int PROD_W    = 2 * MUL_W;
  localparam int SUM_W     = 2 * SCL_W + 2;      // sum of three squares
  localparam int RAD_W     = SUM_W + SCL_W;      // square root radicand
  localparam int ROOT_W    = RAD_W / 2;
  localparam int DIV_SHIFT = 24;
  localparam int NUM_W     = DIV_SHIFT + SCL_W + 2;
  localparam int QUO_W     = 16;
  localparam int STEP_W    = 5;

  localparam logic [QUO_W-1:0] ONE_Q14 = QUO_W'(16384);

  // Saturate a quotient to one in Q1.14 and give it the component sign
  function automatic logic [OUT_W-1:0] q14_pack(input logic [QUO_W-1:0] q, input logic neg);
    logic [OUT_W-1:0] sat;
    sat = (q > ONE_Q14) ? OUT_W'(ONE_Q14) : OUT_W'(q);
    return neg ? OUT_W'(-sat) : sat;
  endfunction

endpackage

### design/triangle_face_normal.sv
// Triangle face normal unit.
// Slave stream s_*: one triangle per transfer, tdata holds from bit 0 up the
// indices a, b, c and the corners a_x a_y a_z b_x b_y b_z c_x c_y c_z, 16 bits
// each, coordinates signed Q7.8. Master stream m_*: one result per triangle,
// tdata holds the three indices and normal x, y, z in signed Q1.14; tuser is
// the degenerate flag (zero normal), tlast marks the last triangle of a pass.
// cfg_we/cfg_wdata write the triangle count of a pass; write it while idle.
// One triangle at a time goes through a shared 21x21 multiplier and one
// shared 62-bit subtractor under a sequencer: cross product, block scaling
// by k one-bit shifts (k = distance of the largest component's bit length
// from 20, 0..19), sum of squares, square root at one root bit a cycle and
// division of each of the three components at one quotient bit a cycle.
// A degenerate triangle leaves the sequence after the cross product check.
// s_tready rises again together with m_tvalid.
// A finished result waits in the output register while the next triangle is
// taken and worked on; when the receiver stalls, the sequencer waits in idle
// with the result held and takes no new triangle until the output register is free.
// Reset clears the pass counter, sets the triangle count to 1 and empties
// the output register.
module triangle_face_normal
  import tfn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CNT_W-1:0]     cfg_wdata,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // a_idx, b_idx, c_idx, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  input  logic [191:0]         s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // a_idx, b_idx, c_idx, normal_x, normal_y, normal_z
  output logic [95:0]          m_tdata,
  // degenerate
  output logic [0:0]           m_tuser,
  output logic                 m_tlast
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_CHK, ST_SCALE, ST_SQR, ST_SQRT, ST_DLOAD, ST_DIV
  } state_t;

  state_t state;
  logic   fin;

  logic [INDEX_W-1:0]        idx [3];
  logic signed [DIFF_W-1:0]  u [3];
  logic signed [DIFF_W-1:0]  v [3];
  logic signed [PROD_W-1:0]  prod;
  logic signed [CROSS_W-1:0] xc [3];
  logic [MAG_W-1:0]          mag [3];
  logic                      neg [3];
  logic [MAG_W-1:0]          orv;
  logic [SUM_W-1:0]          ssum;
  logic [RAD_W-1:0]          sq_n;
  logic [RAD_W-1:0]          sq_res;
  logic [RAD_W-1:0]          sq_bit;
  logic [ROOT_W-1:0]         root;
  logic [NUM_W-1:0]          rem;
  logic [NUM_W-1:0]          dreg;
  logic [QUO_W-1:0]          quo;
  logic [STEP_W-1:0]         step;
  logic [1:0]                comp;
  logic [OUT_W-1:0]          nrm [3];
  logic                      degen;
  logic [CNT_W-1:0]          done_cnt;
  logic [CNT_W-1:0]          tri_count;

  logic signed [COORD_W-1:0] crd [9];
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic [RAD_W-1:0]          sub_a, sub_b;
  logic [RAD_W:0]            sub_diff;
  logic                      sub_ge;
  logic [MAG_W-1:0]          xmag [3];
  logic [SUM_W-1:0]          sum_next;
  logic [RAD_W-1:0]          res_next;
  logic [QUO_W-1:0]          quo_next;
  logic [CNT_W-1:0]          cnt_next;
  logic                      cnt_last;
  logic                      out_load;

  assign s_tready = (state == ST_IDLE) && !fin;

  // Unpack the corner coordinates
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      crd[i] = s_tdata[(3 + i) * COORD_W +: COORD_W];
    end
  end

  // Select shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_MUL) begin
      case (step)
        5'd0: begin mul_a = MUL_W'(u[1]); mul_b = MUL_W'(v[2]); end
        5'd1: begin mul_a = MUL_W'(u[2]); mul_b = MUL_W'(v[1]); end
        5'd2: begin mul_a = MUL_W'(u[2]); mul_b = MUL_W'(v[0]); end
        5'd3: begin mul_a = MUL_W'(u[0]); mul_b = MUL_W'(v[2]); end
        5'd4: begin mul_a = MUL_W'(u[0]); mul_b = MUL_W'(v[1]); end
        5'd5: begin mul_a = MUL_W'(u[1]); mul_b = MUL_W'(v[0]); end
        default: ;
      endcase
    end else if (state == ST_SQR) begin
      case (step)
        5'd0: begin mul_a = {1'b0, mag[0][SCL_W-1:0]}; mul_b = {1'b0, mag[0][SCL_W-1:0]}; end
        5'd1: begin mul_a = {1'b0, mag[1][SCL_W-1:0]}; mul_b = {1'b0, mag[1][SCL_W-1:0]}; end
        5'd2: begin mul_a = {1'b0, mag[2][SCL_W-1:0]}; mul_b = {1'b0, mag[2][SCL_W-1:0]}; end
        default: ;
      endcase
    end
  end

  // Shared subtractor: square root trial and division trial
  always_comb begin
    if (state == ST_SQRT) begin
      sub_a = sq_n;
      // res and bit never overlap here, so res + bit is an OR
      sub_b = sq_res | sq_bit;
    end else begin
      sub_a = RAD_W'(rem);
      sub_b = RAD_W'(dreg);
    end
    sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    sub_ge   = !sub_diff[RAD_W];
  end

  // Magnitudes, running sums and next values
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xmag[i] = xc[i][CROSS_W-1] ? MAG_W'(-xc[i]) : MAG_W'(xc[i]);
    end
    sum_next = ssum + SUM_W'(prod);
    res_next = sub_ge ? ((sq_res >> 1) | sq_bit) : (sq_res >> 1);
    quo_next = {quo[QUO_W-2:0], sub_ge};
    cnt_next = done_cnt + CNT_W'(1);
    cnt_last = (cnt_next == tri_count);
    out_load = fin && (!m_tvalid || m_tready);
  end

  // Sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;

    if (rst) begin
      state     <= ST_IDLE;
      fin       <= 1'b0;
      step      <= '0;
      comp      <= '0;
      m_tvalid  <= 1'b0;
      done_cnt  <= '0;
      tri_count <= CNT_W'(1);
    end else begin
      if (cfg_we) begin
        tri_count <= cfg_wdata;
      end

      // Load a finished result, else drop the one just transferred
      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {nrm[2], nrm[1], nrm[0], idx[2], idx[1], idx[0]};
        m_tuser  <= degen;
        m_tlast  <= cnt_last;
        done_cnt <= cnt_last ? '0 : cnt_next;
        fin      <= 1'b0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            for (int i = 0; i < 3; i++) begin
              idx[i] <= s_tdata[i * INDEX_W +: INDEX_W];
              u[i]   <= DIFF_W'(crd[i]) - DIFF_W'(crd[3 + i]);
              v[i]   <= DIFF_W'(crd[i]) - DIFF_W'(crd[6 + i]);
            end
            step  <= '0;
            state <= ST_MUL;
          end
        end

        // Accumulate the cross product one product behind the issue
        ST_MUL: begin
          case (step)
            5'd1: xc[0] <= CROSS_W'(prod);
            5'd2: xc[0] <= xc[0] - CROSS_W'(prod);
            5'd3: xc[1] <= CROSS_W'(prod);
            5'd4: xc[1] <= xc[1] - CROSS_W'(prod);
            5'd5: xc[2] <= CROSS_W'(prod);
            5'd6: xc[2] <= xc[2] - CROSS_W'(prod);
            default: ;
          endcase
          if (step == 5'd6) begin
            state <= ST_CHK;
          end else begin
            step <= step + 5'd1;
          end
        end

        // Split into sign and magnitude, catch the zero cross product
        ST_CHK: begin
          for (int i = 0; i < 3; i++) begin
            mag[i] <= xmag[i];
            neg[i] <= xc[i][CROSS_W-1];
            nrm[i] <= '0;
          end
          orv <= xmag[0] | xmag[1] | xmag[2];
          if ((xmag[0] | xmag[1] | xmag[2]) == '0) begin
            degen <= 1'b1;
            fin   <= 1'b1;
            state <= ST_IDLE;
          end else begin
            degen <= 1'b0;
            state <= ST_SCALE;
          end
        end

        // Shift one bit a cycle until the largest magnitude is in [2^19, 2^20)
        ST_SCALE: begin
          if (orv[MAG_W-1:SCL_W] != '0) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= mag[i] >> 1;
            end
            orv <= orv >> 1;
          end else if (!orv[SCL_W-1]) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= mag[i] << 1;
            end
            orv <= orv << 1;
          end else begin
            ssum  <= '0;
            step  <= '0;
            state <= ST_SQR;
          end
        end

        // Sum the squares, then load the square root radicand
        ST_SQR: begin
          if (step != '0) begin
            ssum <= sum_next;
          end
          if (step == 5'd3) begin
            sq_n   <= {sum_next, {SCL_W{1'b0}}};
            sq_res <= '0;
            sq_bit <= RAD_W'(1) << (RAD_W - 2);
            step   <= '0;
            state  <= ST_SQRT;
          end else begin
            step <= step + 5'd1;
          end
        end

        // One root bit per cycle
        ST_SQRT: begin
          if (sub_ge) begin
            sq_n <= sub_diff[RAD_W-1:0];
          end
          sq_res <= res_next;
          sq_bit <= sq_bit >> 2;
          if (step == STEP_W'(ROOT_W - 1)) begin
            root  <= res_next[ROOT_W-1:0];
            comp  <= '0;
            state <= ST_DLOAD;
          end else begin
            step <= step + 5'd1;
          end
        end

        // Load the rounded dividend of one component
        ST_DLOAD: begin
          rem   <= NUM_W'({mag[comp][SCL_W-1:0], {DIV_SHIFT{1'b0}}}) + NUM_W'(root >> 1);
          dreg  <= NUM_W'(root) << (QUO_W - 1);
          quo   <= '0;
          step  <= '0;
          state <= ST_DIV;
        end

        // One quotient bit per cycle
        ST_DIV: begin
          if (sub_ge) begin
            rem <= sub_diff[NUM_W-1:0];
          end
          quo  <= quo_next;
          dreg <= dreg >> 1;
          if (step == STEP_W'(QUO_W - 1)) begin
            nrm[comp] <= q14_pack(quo_next, neg[comp]);
            if (comp == 2'd2) begin
              fin   <= 1'b1;
              state <= ST_IDLE;
            end else begin
              comp  <= comp + 2'd1;
              state <= ST_DLOAD;
            end
          end else begin
            step <= step + 5'd1;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[95:48] == '0)
    else $error("degenerate result with nonzero normal");

  a_normal_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[95:48] != '0)
    else $error("regular result with zero normal");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a triangle is in work");

  a_pass_wrap: assert property (@(posedge clk) disable iff (rst)
    out_load && cnt_last |=> done_cnt == '0 && m_tlast && m_tvalid)
    else $error("pass counter not cleared on last triangle");
`endif

endmodule
